// ===== rtl/pidds_pkg.sv =====
// Shared types and constants for the PID differential steering block.
package pidds_pkg;

   // Register indexes on the configuration channel
   localparam logic [2:0] CSR_PROP_GAIN    = 3'd0;
   localparam logic [2:0] CSR_INTEG_GAIN   = 3'd1;
   localparam logic [2:0] CSR_DERIV_GAIN   = 3'd2;
   localparam logic [2:0] CSR_GOAL_HEADING = 3'd3;
   localparam logic [2:0] CSR_CRUISE_SPEED = 3'd4;

   // Register values after reset
   localparam logic signed [15:0] PROP_GAIN_RESET    = 16'sd8192;
   localparam logic signed [15:0] INTEG_GAIN_RESET   = 16'sd41;
   localparam logic signed [15:0] DERIV_GAIN_RESET   = 16'sd4096;
   localparam logic signed [15:0] GOAL_HEADING_RESET = 16'sd0;
   localparam logic [6:0]         CRUISE_SPEED_RESET = 7'd50;

   // Wheel drive limit and fraction bits of the weighted sum
   localparam logic [6:0] WHEEL_MAX = 7'd100;
   localparam int         FRAC_BITS = 20;

   typedef struct packed {
      logic signed [15:0] measured_angle;
      logic               restart;
   } req_payload_type;

   typedef struct packed {
      logic [6:0]         left_drive;
      logic [6:0]         right_drive;
      logic signed [15:0] correction;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0]  addr;
      logic [15:0] data;
   } csr_payload_type;

   // Register file contents as seen by the datapath
   typedef struct packed {
      logic signed [15:0] prop_gain;
      logic signed [15:0] integ_gain;
      logic signed [15:0] deriv_gain;
      logic signed [15:0] goal_heading;
      logic [6:0]         cruise_speed;
   } cfg_type;

endpackage

// ===== rtl/pidds_stream_if.sv =====
// Valid/ready channel carrying one payload per beat.
interface pidds_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/pid_differential_steering.sv =====
// Top level of the positional PID differential steering controller.
//
// One heading sample is taken per beat and one wheel command comes out per
// sample, through the stage 1, 2 and 3 and output registers; a new sample
// may enter in every cycle while the output is not stalled. At acceptance the
// error, the saturating 32-bit error sum and the derivative are formed and
// the integrator state is updated in the same cycle, which is what sets the
// one-sample-per-cycle rate. The three gain products are then registered,
// summed, and in the last stage the sum is truncated toward zero by 2^20,
// saturated to 16 bits and applied to the base speed, each wheel clamped to
// 0..100. A restart flag clears the error sum and the previous error before
// its own sample is used. Configuration writes take effect immediately and
// should be made while no sample is in flight.
module pid_differential_steering (
   input  logic          clock,
   input  logic          reset,
   pidds_stream_if.sink   req_ch,
   pidds_stream_if.source rsp_ch,
   pidds_stream_if.sink   csr_ch
);
   import pidds_pkg::*;

   cfg_type cfg;

   pidds_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // Integrator state
   logic signed [31:0] error_sum_ff, error_sum_in;
   logic signed [16:0] last_error_ff;

   // Stage 1: error terms
   logic               s1_valid_ff;
   logic signed [16:0] s1_err_ff, s1_err_in;
   logic signed [31:0] s1_sum_ff;
   logic signed [17:0] s1_deriv_ff, s1_deriv_in;

   // Stage 2: gain products
   logic               s2_valid_ff;
   logic signed [32:0] s2_prop_ff, s2_prop_in;
   logic signed [47:0] s2_integ_ff, s2_integ_in;
   logic signed [33:0] s2_deriv_ff, s2_deriv_in;

   // Stage 3: weighted sum, Q.20
   logic               s3_valid_ff;
   logic signed [49:0] s3_acc_ff, s3_acc_in;

   // Output stage
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   logic accept;
   logic out_load, s3_load, s2_load, s1_load;

   // Stall chain: a stage loads when it is empty or its successor moves on
   assign out_load = !rsp_valid_ff || rsp_ch.ready;
   assign s3_load  = !s3_valid_ff || out_load;
   assign s2_load  = !s2_valid_ff || s3_load;
   assign s1_load  = !s1_valid_ff || s2_load;

   assign req_ch.ready = s1_load;
   assign accept       = req_ch.valid && s1_load;

   // Error, saturating integral and derivative of the incoming sample
   logic signed [31:0] sum_base;
   logic signed [16:0] last_base;
   logic signed [32:0] sum_wide;

   always_comb begin
      sum_base  = req_ch.payload.restart ? 32'sd0 : error_sum_ff;
      last_base = req_ch.payload.restart ? 17'sd0 : last_error_ff;
      s1_err_in = 17'(cfg.goal_heading) - 17'(req_ch.payload.measured_angle);
      sum_wide  = 33'(sum_base) + 33'(s1_err_in);
      if (sum_wide[32] != sum_wide[31]) begin
         error_sum_in = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         error_sum_in = sum_wide[31:0];
      end
      s1_deriv_in = 18'(s1_err_in) - 18'(last_base);
   end

   // Gain products
   assign s2_prop_in  = cfg.prop_gain * s1_err_ff;
   assign s2_integ_in = cfg.integ_gain * s1_sum_ff;
   assign s2_deriv_in = cfg.deriv_gain * s1_deriv_ff;

   // Weighted sum
   assign s3_acc_in = 50'(s2_prop_ff) + 50'(s2_integ_ff) + 50'(s2_deriv_ff);

   // Truncate toward zero, saturate, then steer the wheels
   logic signed [29:0] quot;
   logic signed [15:0] corr;
   logic signed [17:0] left_wide, right_wide;
   logic signed [17:0] base_wide;

   always_comb begin
      quot = s3_acc_ff[49:FRAC_BITS];
      if (s3_acc_ff[49] && (|s3_acc_ff[FRAC_BITS-1:0])) begin
         quot = quot + 30'sd1;
      end
      if (quot > 30'sd32767) begin
         corr = 16'sh7fff;
      end else if (quot < -30'sd32768) begin
         corr = 16'sh8000;
      end else begin
         corr = quot[15:0];
      end
      base_wide  = $signed({11'd0, cfg.cruise_speed});
      left_wide  = base_wide - 18'(corr);
      right_wide = base_wide + 18'(corr);

      rsp_payload_in.correction = corr;
      if (left_wide < 18'sd0) begin
         rsp_payload_in.left_drive = 7'd0;
      end else if (left_wide > 18'(WHEEL_MAX)) begin
         rsp_payload_in.left_drive = WHEEL_MAX;
      end else begin
         rsp_payload_in.left_drive = left_wide[6:0];
      end
      if (right_wide < 18'sd0) begin
         rsp_payload_in.right_drive = 7'd0;
      end else if (right_wide > 18'(WHEEL_MAX)) begin
         rsp_payload_in.right_drive = WHEEL_MAX;
      end else begin
         rsp_payload_in.right_drive = right_wide[6:0];
      end
   end

   // Control: state and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         last_error_ff <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            error_sum_ff  <= error_sum_in;
            last_error_ff <= s1_err_in;
         end
         if (s1_load)  s1_valid_ff  <= req_ch.valid;
         if (s2_load)  s2_valid_ff  <= s1_valid_ff;
         if (s3_load)  s3_valid_ff  <= s2_valid_ff;
         if (out_load) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // Payload: advance each stage with its beat
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_err_ff   <= s1_err_in;
         s1_sum_ff   <= error_sum_in;
         s1_deriv_ff <= s1_deriv_in;
      end
      if (s2_load && s1_valid_ff) begin
         s2_prop_ff  <= s2_prop_in;
         s2_integ_ff <= s2_integ_in;
         s2_deriv_ff <= s2_deriv_in;
      end
      if (s3_load && s2_valid_ff) begin
         s3_acc_ff <= s3_acc_in;
      end
      if (out_load && s3_valid_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_payload_ff;

   // The integrator state matches the terms handed to stage 1
   a_state_tracks_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> (error_sum_ff == s1_sum_ff) && (last_error_ff == s1_err_ff))
      else $error("integrator state differs from stage 1 terms");

   // After a restart the derivative equals the error
   a_restart_deriv: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.payload.restart |=> s1_deriv_ff == 18'(s1_err_ff))
      else $error("restart did not clear the previous error");

   // Wheel commands stay within range
   a_wheel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.left_drive <= WHEEL_MAX)
                    && (rsp_payload_ff.right_drive <= WHEEL_MAX))
      else $error("wheel command above limit");

   // A non-negative correction never drives the left wheel above the right
   a_steer_sense: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_payload_ff.correction[15]
         |-> rsp_payload_ff.left_drive <= rsp_payload_ff.right_drive)
      else $error("steering applied with the wrong sense");

endmodule

// ===== rtl/pidds_csr.sv =====
// Configuration register file of the PID differential steering block.
module pidds_csr (
   input  logic                clock,
   input  logic                reset,
   pidds_stream_if.sink        csr_ch,
   output pidds_pkg::cfg_type  cfg
);
   import pidds_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Take a write beat in every cycle
   assign csr_ch.ready = 1'b1;

   // Decode the register index; drop writes to unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.payload.addr)
            CSR_PROP_GAIN:    cfg_in.prop_gain    = csr_ch.payload.data;
            CSR_INTEG_GAIN:   cfg_in.integ_gain   = csr_ch.payload.data;
            CSR_DERIV_GAIN:   cfg_in.deriv_gain   = csr_ch.payload.data;
            CSR_GOAL_HEADING: cfg_in.goal_heading = csr_ch.payload.data;
            CSR_CRUISE_SPEED: cfg_in.cruise_speed = csr_ch.payload.data[6:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain    <= PROP_GAIN_RESET;
         cfg_ff.integ_gain   <= INTEG_GAIN_RESET;
         cfg_ff.deriv_gain   <= DERIV_GAIN_RESET;
         cfg_ff.goal_heading <= GOAL_HEADING_RESET;
         cfg_ff.cruise_speed <= CRUISE_SPEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
